/* rtl/core/ihl_pkg.sv */
// Shared types, constants and helpers of the Intel HEX line loader.
// Used by ihl_front, ihl_queue, ihl_back and intel_hex_line_loader.
package ihl_pkg;

  typedef enum logic [1:0] {
    KIND_ERASE  = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] CFG_START_CHAR  = 3'd0;
  localparam logic [2:0] CFG_LINE_BREAK  = 3'd1;
  localparam logic [2:0] CFG_END_CHAR    = 3'd2;
  localparam logic [2:0] CFG_UPDATE_BASE = 3'd3;
  localparam logic [2:0] CFG_INFO_ADDR   = 3'd4;

  localparam logic [7:0]  RST_START_CHAR  = 8'h02;
  localparam logic [7:0]  RST_LINE_BREAK  = 8'h0A;
  localparam logic [7:0]  RST_END_CHAR    = 8'h04;
  localparam logic [31:0] RST_UPDATE_BASE = 32'h0804_0000;
  localparam logic [31:0] RST_INFO_ADDR   = 32'h0800_C000;

  localparam logic [7:0]  DIGIT_OFFSET  = 8'd48;
  localparam logic [7:0]  LETTER_OFFSET = 8'd55;
  localparam logic [7:0]  ODD_PAD       = 8'hFF;
  localparam logic [3:0]  TYPE_DATA     = 4'd0;
  localparam logic [3:0]  TYPE_EXT_LIN  = 4'd4;

  // request from front to back; KIND_ACK marks a completed line
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [7:0]  hw_count;
    logic [7:0]  hw_valid;
    logic        odd;
    logic [6:0]  odd_index;
  } cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = 4'(c - DIGIT_OFFSET);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = 4'(c - LETTER_OFFSET);
    end
    return v;
  endfunction

endpackage

/* rtl/core/ihl_front.sv */
// Front end: configuration registers, character decode and line header state.
// Writes the halfword store and issues requests; depends on ihl_pkg.
module ihl_front #(
  parameter int LINE_CHARS    = 128,
  parameter int MAX_HALFWORDS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output ihl_pkg::cmd_t                    q_cmd,
  input  logic                             line_done,
  output logic                             st_we,
  output logic [$clog2(MAX_HALFWORDS)-1:0] st_addr,
  output logic [15:0]                      st_data
);

  localparam int PW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(MAX_HALFWORDS);

  logic [7:0]    start_char;
  logic [7:0]    line_break_char;
  logic [7:0]    end_char;
  logic [31:0]   update_base_address;
  logic [31:0]   info_address;
  logic [PW-1:0] char_position;
  logic [7:0]    byte_count;
  logic [15:0]   low_address;
  logic [3:0]    type_digit;
  logic [15:0]   acc;
  logic [31:0]   write_address;
  logic [23:0]   firmware_size;
  logic          finished;
  logic          line_pending;

  logic          accept;
  logic [3:0]    v;
  logic          is_start, is_lb, is_end, take, in_data;
  logic [PW-1:0] q;
  logic [31:0]   k32;
  logic [1:0]    j;
  logic [15:0]   acc_next;
  logic [8:0]    cnt9;
  logic [7:0]    hw_count;
  logic [31:0]   cp32, nv32;
  logic [31:0]   line_addr;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full && !line_pending;
  assign accept    = s_tvalid && s_tready;
  assign v         = ihl_pkg::hex_value(s_tdata);
  assign is_start  = (s_tdata == start_char);
  assign is_lb     = !is_start && (s_tdata == line_break_char);
  assign is_end    = !is_start && !is_lb && (s_tdata == end_char);
  assign take      = !finished && !is_start && !is_lb && !is_end
                     && (32'(char_position) < LINE_CHARS);
  assign in_data   = (char_position >= PW'(9));
  assign q         = char_position - PW'(9);
  assign k32       = 32'(q >> 2);
  assign j         = q[1:0];
  assign line_addr = {write_address[31:16], low_address};

  always_comb begin
    case (j)
      2'd0:    acc_next = {8'h00, v, 4'h0};
      2'd1:    acc_next = acc | {12'h000, v};
      2'd2:    acc_next = acc | {v, 12'h000};
      default: acc_next = acc | {4'h0, v, 8'h00};
    endcase
  end

  assign st_we   = accept && take && in_data && (k32 < 32'(MAX_HALFWORDS));
  assign st_addr = k32[AW-1:0];
  assign st_data = acc_next;

  always_comb begin
    cnt9 = ({1'b0, byte_count} + 9'd1) >> 1;
    if (cnt9 > 9'(MAX_HALFWORDS)) begin
      hw_count = 8'(MAX_HALFWORDS);
    end else begin
      hw_count = cnt9[7:0];
    end
    cp32 = 32'(char_position);
    nv32 = (cp32 > 32'd9) ? ((cp32 - 32'd6) >> 2) : 32'd0;
    if (nv32 > 32'(MAX_HALFWORDS)) begin
      nv32 = 32'(MAX_HALFWORDS);
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_cmd  = '0;
    if (accept && !finished) begin
      if (is_start) begin
        q_push      = 1'b1;
        q_cmd.kind  = ihl_pkg::KIND_ERASE;
        q_cmd.addr  = update_base_address;
      end else if (is_lb) begin
        q_push      = 1'b1;
        q_cmd.kind  = ihl_pkg::KIND_ACK;
        if (type_digit == ihl_pkg::TYPE_DATA) begin
          q_cmd.addr      = line_addr;
          q_cmd.hw_count  = hw_count;
          q_cmd.hw_valid  = nv32[7:0];
          q_cmd.odd       = byte_count[0];
          q_cmd.odd_index = byte_count[7:1];
        end
      end else if (is_end) begin
        q_push      = 1'b1;
        q_cmd.kind  = ihl_pkg::KIND_FINISH;
        q_cmd.addr  = info_address;
        q_cmd.data  = {firmware_size, 8'h01};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char          <= ihl_pkg::RST_START_CHAR;
      line_break_char     <= ihl_pkg::RST_LINE_BREAK;
      end_char            <= ihl_pkg::RST_END_CHAR;
      update_base_address <= ihl_pkg::RST_UPDATE_BASE;
      info_address        <= ihl_pkg::RST_INFO_ADDR;
      char_position       <= '0;
      byte_count          <= '0;
      low_address         <= '0;
      type_digit          <= '0;
      write_address       <= '0;
      firmware_size       <= '0;
      finished            <= 1'b0;
      line_pending        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ihl_pkg::CFG_START_CHAR:  start_char          <= cfg_data[7:0];
          ihl_pkg::CFG_LINE_BREAK:  line_break_char     <= cfg_data[7:0];
          ihl_pkg::CFG_END_CHAR:    end_char            <= cfg_data[7:0];
          ihl_pkg::CFG_UPDATE_BASE: update_base_address <= cfg_data;
          ihl_pkg::CFG_INFO_ADDR:   info_address        <= cfg_data;
          default: ;
        endcase
      end
      if (line_done) begin
        line_pending <= 1'b0;
      end
      if (accept && !finished) begin
        if (is_start || is_lb) begin
          char_position <= '0;
          byte_count    <= '0;
          low_address   <= '0;
          type_digit    <= '0;
        end
        if (is_lb) begin
          line_pending <= 1'b1;
          if (type_digit == ihl_pkg::TYPE_EXT_LIN) begin
            write_address <= update_base_address;
          end else if (type_digit == ihl_pkg::TYPE_DATA) begin
            write_address <= line_addr;
            firmware_size <= firmware_size + {16'h0000, byte_count};
          end
        end
        if (is_end) begin
          finished <= 1'b1;
        end
        if (take) begin
          char_position <= char_position + PW'(1);
          case (32'(char_position))
            32'd1:   byte_count          <= {v, 4'h0};
            32'd2:   byte_count[3:0]     <= v;
            32'd3:   low_address[15:12]  <= v;
            32'd4:   low_address[11:8]   <= v;
            32'd5:   low_address[7:4]    <= v;
            32'd6:   low_address[3:0]    <= v;
            32'd8:   type_digit          <= v;
            default: ;
          endcase
          if (in_data) begin
            acc <= acc_next;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/ihl_queue.sv */
// Two-entry request queue between front and back of the line loader.
// Depends on ihl_pkg for the request type.
module ihl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ihl_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ihl_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  ihl_pkg::cmd_t entry [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;

  assign head  = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/ihl_back.sv */
// Back end: halfword store, write sequencer and registered output stage.
// Depends on ihl_pkg; fed by ihl_queue and ihl_front.
module ihl_back #(
  parameter int MAX_HALFWORDS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  ihl_pkg::cmd_t                    q_cmd,
  input  logic                             st_we,
  input  logic [$clog2(MAX_HALFWORDS)-1:0] st_addr,
  input  logic [15:0]                      st_data,
  output logic                             line_done,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast
);

  localparam int AW = $clog2(MAX_HALFWORDS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WRITE, S_ACK, S_ONE} state_t;

  state_t        state;
  ihl_pkg::cmd_t cmd;
  logic [7:0]    k;
  logic [31:0]   cur_addr;
  logic [15:0]   store [MAX_HALFWORDS];
  logic [15:0]   rdata;
  logic          load_ok;
  logic          emit;
  logic [15:0]   hw_base;
  logic [15:0]   hw;

  assign load_ok   = !m_tvalid || m_tready;
  assign emit      = load_ok && ((state == S_WRITE) || (state == S_ACK) || (state == S_ONE));
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign line_done = (state == S_ACK) && load_ok;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_addr] <= st_data;
    end
    rdata <= store[k[AW-1:0]];
  end

  always_comb begin
    hw_base = (k < cmd.hw_valid) ? rdata : 16'h0000;
    hw      = hw_base;
    if (cmd.odd && (k == {1'b0, cmd.odd_index})) begin
      hw = {ihl_pkg::ODD_PAD, hw_base[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      k        <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd      <= q_cmd;
            k        <= '0;
            cur_addr <= q_cmd.addr;
            if (q_cmd.kind == ihl_pkg::KIND_ACK) begin
              state <= (q_cmd.hw_count == 8'd0) ? S_ACK : S_READ;
            end else begin
              state <= S_ONE;
            end
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          if (load_ok) begin
            m_tuser  <= ihl_pkg::KIND_WRITE;
            m_tdata  <= {16'h0000, hw, cur_addr};
            m_tlast  <= 1'b0;
            cur_addr <= cur_addr + 32'd2;
            k        <= k + 8'd1;
            state    <= (k + 8'd1 == cmd.hw_count) ? S_ACK : S_READ;
          end
        end
        S_ACK: begin
          if (load_ok) begin
            m_tuser  <= ihl_pkg::KIND_ACK;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_ONE: begin
          if (load_ok) begin
            m_tuser  <= cmd.kind;
            m_tdata  <= {cmd.data, cmd.addr};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_gives_ack: assert property (@(posedge clk) disable iff (rst)
    line_done |=> m_tvalid && m_tlast && (m_tuser == ihl_pkg::KIND_ACK))
    else $error("line completion without acknowledge");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (k < cmd.hw_count))
    else $error("halfword index past line count");

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ihl_pkg::KIND_WRITE)) |-> !m_tlast)
    else $error("halfword write marked last");

endmodule

/* rtl/core/intel_hex_line_loader.sv */
// Intel HEX line loader: parses an update character stream into flash requests.
// Top level; instantiates ihl_front, ihl_queue and ihl_back, uses ihl_pkg.
//
// Each character is taken in one cycle while the request queue has room. A
// start character gives one erase result and the end character one finish
// result; a line break gives an acknowledge, preceded for a data record by one
// halfword write per byte pair (up to MAX_HALFWORDS). Halfwords are read from
// the store through a registered read port, each in a read state and then a
// write state, and no character after a line break is taken until that line's
// acknowledge has entered the output register.
// Results leave through a registered stream output; tuser is the result kind
// (0 erase, 1 write, 2 acknowledge, 3 finish), tlast marks the final result
// of a character. After the end character every input is taken and dropped.
module intel_hex_line_loader #(
  parameter int LINE_CHARS    = 128,
  parameter int MAX_HALFWORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] flash_address, [63:32] payload
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_HALFWORDS);

  ihl_pkg::cmd_t push_cmd;
  ihl_pkg::cmd_t head_cmd;
  logic          q_push, q_pop, q_empty, q_full;
  logic          line_done;
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [15:0]   st_data;

  ihl_front #(
    .LINE_CHARS   (LINE_CHARS),
    .MAX_HALFWORDS(MAX_HALFWORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .line_done(line_done),
    .st_we    (st_we),
    .st_addr  (st_addr),
    .st_data  (st_data)
  );

  ihl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .head    (head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  ihl_back #(
    .MAX_HALFWORDS(MAX_HALFWORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cmd    (head_cmd),
    .st_we    (st_we),
    .st_addr  (st_addr),
    .st_data  (st_data),
    .line_done(line_done),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
